// File: hw/rtl/substring_matcher_case_fold_macros.svh
// Assertion macros shared by the substring matcher RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SUBSTRING_MATCHER_CASE_FOLD_MACROS_SVH
`define SUBSTRING_MATCHER_CASE_FOLD_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define SCM_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("same-cycle check failed");

// A condition that must hold in the cycle after its trigger.
`define SCM_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/scm_pkg.sv
// Shared types, constants and helper functions of the substring matcher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package scm_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int LINE_MAX    = 256;
   localparam int COL_W       = $clog2(LINE_MAX);
   localparam int PIDX_W      = $clog2(PATTERN_MAX);
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int WIN_DEPTH   = PATTERN_MAX - 1;
   localparam int CNT_W       = $clog2(PATTERN_MAX);
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_CASE  = 2'd3;

   typedef struct packed {
      logic [7:0]       text_byte;
      logic             line_begin;
      logic [COL_W-1:0] begin_column;
   } req_payload_type;

   typedef struct packed {
      logic             match_found;
      logic [COL_W-1:0] match_column;
   } rsp_payload_type;

   typedef struct packed {
      logic [8*PATTERN_MAX-1:0] pattern;
      logic [4:0]               pattern_length;
      logic                     ignore_case;
   } cfg_type;

   // Fold ASCII a-z to A-Z when folding is enabled.
   function automatic logic [7:0] fold(input logic [7:0] c, input logic enable);
      logic [7:0] r;
      r = c;
      if (enable && c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic [7:0] pattern_byte(input logic [8*PATTERN_MAX-1:0] pat,
                                               input logic [PIDX_W-1:0] idx);
      return pat[8*idx +: 8];
   endfunction

endpackage

// File: hw/rtl/scm_csr.sv
// Configuration registers of the substring matcher.
// Depends on scm_pkg for register codes and the configuration struct.
`timescale 1ns / 1ps

module scm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [scm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output scm_pkg::cfg_type                    cfg
);

   logic [63:0] pattern_low_ff,  pattern_low_in;
   logic [63:0] pattern_high_ff, pattern_high_in;
   logic [4:0]  pattern_length_ff, pattern_length_in;
   logic        ignore_case_ff, ignore_case_in;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      ignore_case_in    = ignore_case_ff;
      if (csr_wen) begin
         unique case (csr_index)
            scm_pkg::CSR_PATTERN_LOW:  pattern_low_in    = csr_wdata;
            scm_pkg::CSR_PATTERN_HIGH: pattern_high_in   = csr_wdata;
            scm_pkg::CSR_PATTERN_LEN:  pattern_length_in = csr_wdata[4:0];
            scm_pkg::CSR_IGNORE_CASE:  ignore_case_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= 5'd1;
         ignore_case_ff    <= 1'b0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
         ignore_case_ff    <= ignore_case_in;
      end
   end

   assign cfg.pattern        = {pattern_high_ff, pattern_low_ff};
   assign cfg.pattern_length = pattern_length_ff;
   assign cfg.ignore_case    = ignore_case_ff;

endmodule

// File: hw/rtl/scm_core.sv
// Window of recent line bytes, column tracking and the parallel pattern compare.
// Depends on scm_pkg for types, sizes and the fold and pattern byte helpers.
`timescale 1ns / 1ps

module scm_core (
   input  logic                      clock,
   input  logic                      reset,
   input  scm_pkg::cfg_type          cfg,
   input  scm_pkg::req_payload_type  item,
   input  logic                      advance,
   output scm_pkg::rsp_payload_type  result
);

   logic [7:0]                   window_ff [scm_pkg::WIN_DEPTH];
   logic [7:0]                   window_in [scm_pkg::WIN_DEPTH];
   logic [scm_pkg::COL_W-1:0]    column_ff, column_in;
   logic [scm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [scm_pkg::CNT_W-1:0]    count_eff;
   logic [scm_pkg::LEN_W-1:0]    len_eff;
   logic [scm_pkg::LEN_W-1:0]    pidx;
   logic [7:0]                   text_c;
   logic                         hit;

   // Saturate the configured length into the range one to PATTERN_MAX.
   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         len_eff = scm_pkg::LEN_W'(1);
      end else if (cfg.pattern_length > 5'(scm_pkg::PATTERN_MAX)) begin
         len_eff = scm_pkg::LEN_W'(scm_pkg::PATTERN_MAX);
      end else begin
         len_eff = scm_pkg::LEN_W'(cfg.pattern_length);
      end
   end

   always_comb begin
      column_in = item.line_begin ? item.begin_column : column_ff + 1'b1;
      count_eff = item.line_begin ? '0 : count_ff;
      count_in  = (count_eff < scm_pkg::CNT_W'(scm_pkg::WIN_DEPTH)) ?
                  count_eff + 1'b1 : count_eff;
      window_in[0] = item.text_byte;
      for (int k = 1; k < scm_pkg::WIN_DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // Byte k back from the newest is compared with pattern byte len-1-k.
   always_comb begin
      hit    = ({1'b0, count_eff} + scm_pkg::LEN_W'(1)) >= len_eff;
      pidx   = '0;
      text_c = '0;
      for (int k = 0; k < scm_pkg::PATTERN_MAX; k++) begin
         if (k == 0) begin
            text_c = item.text_byte;
         end else begin
            text_c = window_ff[k-1];
         end
         pidx = len_eff - scm_pkg::LEN_W'(1) - scm_pkg::LEN_W'(k);
         if (scm_pkg::LEN_W'(k) < len_eff) begin
            if (scm_pkg::fold(text_c, cfg.ignore_case) !=
                scm_pkg::fold(scm_pkg::pattern_byte(cfg.pattern,
                                                    pidx[scm_pkg::PIDX_W-1:0]),
                              cfg.ignore_case)) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign result.match_found  = hit;
   assign result.match_column = hit ?
      column_in - scm_pkg::COL_W'(len_eff - scm_pkg::LEN_W'(1)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         column_ff <= column_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
      end
   end

endmodule

// File: hw/rtl/substring_matcher_case_fold.sv
// Top level of the case-folding substring matcher: handshakes and stage registers.
// Depends on scm_pkg, scm_csr, scm_core and substring_matcher_case_fold_macros.svh.
//
//   Channel  | Direction | Beat contents                         | Handshake
//   req_     | in        | text_byte, line_begin, begin_column   | valid / stall
//   rsp_     | out       | match_found, match_column             | valid / stall
//   csr_     | in        | register index and 64-bit write data  | write enable
//
// One beat is accepted every cycle while req_stall is low. A beat waits in the input
// register and moves into the result register when that is empty or being taken; its
// result is then offered on rsp_ until it is taken.
// The compare of all sixteen byte positions is done in parallel, combinationally.
// Reset is synchronous and active high; it empties both stages, clears the column
// and the window fill count, and loads the configuration reset values.
// A stall on the result side holds the result register, and the input register
// holds too only when it cannot move on, so stall reaches req_stall in the same cycle.
`timescale 1ns / 1ps
`include "substring_matcher_case_fold_macros.svh"

module substring_matcher_case_fold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  scm_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output scm_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_wen,
   input  logic [scm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   scm_pkg::cfg_type          cfg;
   scm_pkg::req_payload_type  s1_item_ff, s1_item_in;
   logic                      s1_valid_ff, s1_valid_in;
   scm_pkg::rsp_payload_type  out_data_ff, out_data_in;
   logic                      out_valid_ff, out_valid_in;
   scm_pkg::rsp_payload_type  core_result;
   logic                      advance;
   logic                      accept;

   scm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The window state moves only when the held beat passes into the result register.
   scm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (s1_item_ff),
      .advance (advance),
      .result  (core_result)
   );

   // The input register moves on when the result register is empty or being taken.
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_item_in  = accept ? req_payload : s1_item_ff;
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_data_in = advance ? core_result : out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // A beat that moves on must leave a result behind it.
   `SCM_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   // A held beat keeps its contents until it can move on.
   `SCM_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !advance,
                    s1_valid_ff && $stable(s1_item_ff))
   // Back-pressure upstream only when both stages are occupied.
   `SCM_ASSERT_SAME(a_stall_when_full, clock, reset, req_stall,
                    s1_valid_ff && out_valid_ff && rsp_stall)
   // A result without a match carries column zero.
   `SCM_ASSERT_SAME(a_nomatch_column, clock, reset,
                    out_valid_ff && !out_data_ff.match_found,
                    out_data_ff.match_column == '0)

endmodule

// File: test/substring_match_checker.sv
// Checker for the case-folding substring matcher: predicts each result and compares.
// Depends on scm_pkg for the payload types, widths and register indexes.
`timescale 1ns / 1ps

module substring_match_checker
   import scm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     pending_matches
);

   logic [63:0]      pat_low;
   logic [63:0]      pat_high;
   logic [4:0]       pat_len;
   logic             fold_case;
   logic [7:0]       history [WIN_DEPTH];
   logic [COL_W-1:0] column;
   int               fill;
   int               mismatches;
   int               result_index;
   rsp_payload_type  expected_matches [$];

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      if (fold_case && c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] key_byte(input int i);
      if (i < 8) begin
         return pat_low[8*i +: 8];
      end
      return pat_high[8*(i-8) +: 8];
   endfunction

   // Works out the result of one accepted beat and moves the window on.
   function automatic void predict_match(input req_payload_type beat);
      int              len;
      logic            hit;
      logic [7:0]      cand;
      rsp_payload_type r;
      if (beat.line_begin) begin
         fill   = 0;
         column = beat.begin_column;
      end else begin
         column = column + 1'b1;
      end
      if (pat_len == 0) begin
         len = 1;
      end else if (pat_len > PATTERN_MAX) begin
         len = PATTERN_MAX;
      end else begin
         len = int'(pat_len);
      end
      hit = (fill + 1 >= len);
      for (int k = 0; k < len; k++) begin
         if (k == 0) begin
            cand = beat.text_byte;
         end else begin
            cand = history[k-1];
         end
         if (to_upper(cand) != to_upper(key_byte(len - 1 - k))) begin
            hit = 1'b0;
         end
      end
      r.match_found  = hit;
      r.match_column = hit ? column - COL_W'(len - 1) : '0;
      expected_matches.push_back(r);
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = beat.text_byte;
      if (fill < WIN_DEPTH) begin
         fill++;
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 100) begin
         $display("%0t: mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   initial begin
      mismatches      = 0;
      result_index    = 0;
      mismatch_count  = 0;
      pending_matches = 0;
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         pat_low   = '0;
         pat_high  = '0;
         pat_len   = 5'd1;
         fold_case = 1'b0;
         column    = '0;
         fill      = 0;
         foreach (history[i]) history[i] = '0;
         expected_matches.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected", result_index));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_payload.match_found !== want.match_found) begin
                  report_mismatch($sformatf("result %0d match_found %b, expected %b",
                     result_index, rsp_payload.match_found, want.match_found));
               end
               if (rsp_payload.match_column !== want.match_column) begin
                  report_mismatch($sformatf("result %0d match_column %0d, expected %0d",
                     result_index, rsp_payload.match_column, want.match_column));
               end
            end
            result_index++;
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_PATTERN_LOW: begin
                  pat_low = csr_wdata;
               end
               CSR_PATTERN_HIGH: begin
                  pat_high = csr_wdata;
               end
               CSR_PATTERN_LEN: begin
                  pat_len = csr_wdata[4:0];
               end
               CSR_IGNORE_CASE: begin
                  fold_case = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_match(req_payload);
         end
      end
      mismatch_count  <= mismatches;
      pending_matches <= expected_matches.size();
   end

endmodule

// File: test/tb.sv
// Top of the substring matcher testbench: clock, reset, stimulus and the verdict.
// Depends on scm_pkg, the substring_matcher_case_fold block and substring_match_checker.
`timescale 1ns / 1ps

module tb;
   import scm_pkg::*;

   // Twelve random phases of 120 beats each, on top of a short directed opening.
   localparam int RANDOM_PHASES   = 12;
   localparam int BEATS_PER_PHASE = 120;
   // The slowest correct run is some 1500 beats, each slowed by random gaps and
   // stalls, plus the drains between phases; this limit leaves several times that in hand.
   localparam int CYCLE_LIMIT     = 250000;

   // Bytes chosen to sit on and around the edges of the letter ranges, so that
   // folding is tried at its boundaries as well as on ordinary letters.
   localparam logic [7:0] POOL [10] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h7A,
                                        8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_wen     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   int mismatch_count;
   int pending_matches;
   int cycles = 0;

   // A copy of the pattern as last written, used to build beats that match it.
   logic [63:0] key_low  = '0;
   logic [63:0] key_high = '0;
   logic [4:0]  key_len  = 5'd1;
   logic        key_fold = 1'b0;

   // Each side has quiet stretches in which it neither idles nor stalls.
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   substring_matcher_case_fold DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   substring_match_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_matches (pending_matches)
   );

   // A run that hangs is stopped here and counts as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_wait(input logic calm);
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] key_at(input int i);
      if (i < 8) begin
         return key_low[8*i +: 8];
      end
      return key_high[8*(i-8) +: 8];
   endfunction

   // Offers one beat after a random gap and returns at the edge that takes it.
   // The valid is only lowered when there is a gap, so back-to-back beats keep it
   // high without a second assignment in the same step.
   task automatic send_beat(input logic [7:0] text, input logic first,
                            input logic [COL_W-1:0] col);
      int gap;
      if ($urandom_range(0, 29) == 0) begin
         req_calm = !req_calm;
      end
      gap = pick_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_payload.text_byte    <= text;
      req_payload.line_begin   <= first;
      req_payload.begin_column <= col;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering beats and waits until every result has come back. The first
   // step of the loop lets the count catch up with the beat just accepted.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_matches != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers on consecutive edges; only called with the block idle.
   task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic fold);
      key_low   = lo;
      key_high  = hi;
      key_len   = len;
      key_fold  = fold;
      csr_wen   <= 1'b1;
      csr_index <= CSR_PATTERN_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_PATTERN_LEN;
      csr_wdata <= 64'(len);
      @(posedge clock);
      csr_index <= CSR_IGNORE_CASE;
      csr_wdata <= 64'(fold);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // The result side stalls for a random gap, or not at all in a quiet stretch, before taking each result.
   initial begin : result_sink
      int hold;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) begin
            rsp_calm = !rsp_calm;
         end
         hold = pick_wait(rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [7:0]  planned [$];
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      logic [7:0]  text;
      int          used;
      int          pick;
      int          spot;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With the reset pattern, a single zero byte, each zero byte of the text matches.
      // The very first beat carries no line start, so its column follows on
      // from the cleared column.
      send_beat(8'h00, 1'b0, 8'hA5);
      send_beat(8'hFF, 1'b1, 8'hFF);
      drain();

      // Overlapping hits of a short pattern in mixed case, on a line that starts
      // near the top column so that the match column wraps round.
      program_pattern(64'h0000_0000_0061_6261, 64'h0, 5'd3, 1'b1);
      send_beat(8'h41, 1'b1, 8'd254);
      send_beat(8'h62, 1'b0, 8'd0);
      send_beat(8'h41, 1'b0, 8'd0);
      send_beat(8'h42, 1'b0, 8'd0);
      send_beat(8'h61, 1'b0, 8'd0);
      drain();

      // Folding is switched off part way along the same line; the window still
      // holds the raw bytes and is compared under the new mode.
      program_pattern(64'h0000_0000_0061_6261, 64'h0, 5'd3, 1'b0);
      send_beat(8'h62, 1'b0, 8'd0);
      send_beat(8'h61, 1'b0, 8'd0);
      drain();

      // A length above the maximum saturates to sixteen bytes of all ones, taken
      // from both pattern words; only the sixteenth byte of the line can hit.
      program_pattern('1, '1, 5'd31, 1'b0);
      send_beat(8'hFF, 1'b1, 8'd0);
      repeat (15) send_beat(8'hFF, 1'b0, 8'($urandom));
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Mostly short patterns, so that hits are common; now and then an empty
         // length, the full length, an oversized one or a middling one.
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            len = 5'($urandom_range(1, 4));
         end else if (pick == 6) begin
            len = 5'd0;
         end else if (pick == 7) begin
            len = 5'd16;
         end else if (pick == 8) begin
            len = 5'($urandom_range(17, 31));
         end else begin
            len = 5'($urandom_range(5, 15));
         end
         if ($urandom_range(0, 3) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end else begin
            for (int i = 0; i < 8; i++) begin
               lo[8*i +: 8] = POOL[$urandom_range(0, 9)];
               hi[8*i +: 8] = POOL[$urandom_range(0, 9)];
            end
         end
         program_pattern(lo, hi, len, 1'($urandom_range(0, 1)));
         if (key_len == 0) begin
            used = 1;
         end else if (key_len > PATTERN_MAX) begin
            used = PATTERN_MAX;
         end else begin
            used = key_len;
         end

         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // Every so often the pattern itself is queued up, with letters in
            // either case, and sometimes with one bit knocked out of place.
            if (planned.size() == 0 && $urandom_range(0, 5) == 0) begin
               for (int i = 0; i < used; i++) begin
                  text = key_at(i);
                  if (((text >= 8'h61 && text <= 8'h7A) || (text >= 8'h41 && text <= 8'h5A))
                      && $urandom_range(0, 2) == 0) begin
                     text = text ^ 8'h20;
                  end
                  planned.push_back(text);
               end
               if ($urandom_range(0, 4) == 0) begin
                  spot = $urandom_range(0, used - 1);
                  planned[spot] = planned[spot] ^ (8'd1 << $urandom_range(0, 7));
               end
            end
            if (planned.size() != 0) begin
               text = planned.pop_front();
            end else if ($urandom_range(0, 2) == 0) begin
               text = 8'($urandom);
            end else begin
               text = POOL[$urandom_range(0, 9)];
            end
            send_beat(text, ($urandom_range(0, 24) == 0), 8'($urandom));
         end
         planned.delete();
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_matches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
